// ===== sv/bbtp_pkg.sv =====
`default_nettype none

package bbtp_pkg;

	// tag body and stack sizes
	localparam int MAX_TAG_LEN = 15;
	localparam int STACK_DEPTH = 8;

	localparam int LEN_W  = $clog2(MAX_TAG_LEN + 1);
	localparam int TAG_AW = $clog2(MAX_TAG_LEN);
	localparam int FIDX_W = $clog2(MAX_TAG_LEN + 2);
	localparam int LVL_W  = $clog2(STACK_DEPTH + 1);
	localparam int STK_AW = $clog2(STACK_DEPTH);

	// command queue between front and back
	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	localparam logic [31:0] BASE_RGBA_RST     = 32'hFFFF_FFFF;
	localparam logic [7:0]  ALPHA_OPAQUE      = 8'hFF;
	localparam logic [7:0]  CH_OPEN           = 8'h5B;
	localparam logic [7:0]  CH_CLOSE          = 8'h5D;
	localparam logic [7:0]  CH_SLASH          = 8'h2F;
	localparam logic [7:0]  CH_HASH           = 8'h23;
	localparam logic [7:0]  CH_EQUALS         = 8'h3D;

	// length of a colour tag body and of the colour close tag body
	localparam int COLOR_BODY_LEN = 13;
	localparam int CLOSE_COLOR_LEN = 6;

	typedef enum logic [1:0] {
		FS_TEXT,
		FS_TAG,
		FS_FLUSH,
		FS_MARK
	} front_state_t;

	typedef enum logic [3:0] {
		CMD_LIT,
		CMD_MARK,
		CMD_PUSH_B,
		CMD_PUSH_I,
		CMD_PUSH_S,
		CMD_PUSH_C,
		CMD_POP_B,
		CMD_POP_I,
		CMD_POP_S,
		CMD_POP_C
	} cmd_kind_t;

	typedef enum logic [1:0] {
		STY_BOLD,
		STY_ITALIC,
		STY_STRIKE,
		STY_COLOR
	} style_t;

	// one command from the front to the back
	typedef struct packed {
		cmd_kind_t   kind;
		logic [7:0]  data;
		logic        last;
		logic        done;
		logic [23:0] rgb;
	} cmd_t;

endpackage

`default_nettype wire

// ===== sv/bbtp_queue.sv =====
`default_nettype none

module bbtp_queue
	import bbtp_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  cmd_t      push_data,
	output logic      full,
	input  wire logic pop,
	output cmd_t      head,
	output logic      not_empty
);

	cmd_t               entry_q [Q_DEPTH];
	logic [Q_AW-1:0]    wr_ptr_q;
	logic [Q_AW-1:0]    rd_ptr_q;
	logic [Q_CNT_W-1:0] count_q;

	logic do_push;
	logic do_pop;

	// status and head
	always_comb begin
		full      = (count_q == Q_CNT_W'(Q_DEPTH));
		not_empty = (count_q != '0);
		head      = entry_q[rd_ptr_q];
		do_push   = push && !full;
		do_pop    = pop && not_empty;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

// ===== sv/bbtp_front.sv =====
`default_nettype none

module bbtp_front
	import bbtp_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       text_valid,
	output logic            text_stall,
	input  wire logic [7:0] text_byte,
	input  wire logic       end_of_text,
	output logic            cmd_valid,
	output cmd_t            cmd,
	input  wire logic       q_full
);

	front_state_t      state_q;
	front_state_t      state_d;
	logic [7:0]        tag_buf_q [MAX_TAG_LEN];
	logic [LEN_W-1:0]  len_q;
	logic [FIDX_W-1:0] fidx_q;
	logic [7:0]        trail_q;
	logic              trail_end_q;

	logic              accept;
	logic              buf_we;
	logic              len_clr;
	logic              len_inc;
	logic              fidx_clr;
	logic              fidx_inc;
	logic              trail_ld;
	logic [FIDX_W-1:0] fidx_m1;
	logic              tag_hit;
	cmd_kind_t         tag_kind;
	logic [23:0]       tag_rgb;
	logic              hex_ok;
	logic [4:0]        nib [6];

	// hex character to {valid, value}
	function automatic logic [4:0] hex_nib(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= "0" && c <= "9") begin
			r = {1'b1, 4'(c - 8'h30)};
		end else if (c >= "a" && c <= "f") begin
			r = {1'b1, 4'(c - 8'h57)};
		end else if (c >= "A" && c <= "F") begin
			r = {1'b1, 4'(c - 8'h37)};
		end
		return r;
	endfunction

	// classify the buffered tag body
	always_comb begin
		for (int k = 0; k < 6; k++) begin
			nib[k] = hex_nib(tag_buf_q[7 + k]);
		end
		hex_ok  = nib[0][4] & nib[1][4] & nib[2][4] & nib[3][4] & nib[4][4] & nib[5][4];
		tag_rgb = {nib[0][3:0], nib[1][3:0], nib[2][3:0],
			nib[3][3:0], nib[4][3:0], nib[5][3:0]};
		tag_hit  = 1'b1;
		tag_kind = CMD_PUSH_B;
		if (len_q == LEN_W'(1) && tag_buf_q[0] == "b") begin
			tag_kind = CMD_PUSH_B;
		end else if (len_q == LEN_W'(2) && tag_buf_q[0] == CH_SLASH && tag_buf_q[1] == "b") begin
			tag_kind = CMD_POP_B;
		end else if (len_q == LEN_W'(1) && tag_buf_q[0] == "i") begin
			tag_kind = CMD_PUSH_I;
		end else if (len_q == LEN_W'(2) && tag_buf_q[0] == CH_SLASH && tag_buf_q[1] == "i") begin
			tag_kind = CMD_POP_I;
		end else if (len_q == LEN_W'(1) && tag_buf_q[0] == "s") begin
			tag_kind = CMD_PUSH_S;
		end else if (len_q == LEN_W'(2) && tag_buf_q[0] == CH_SLASH && tag_buf_q[1] == "s") begin
			tag_kind = CMD_POP_S;
		end else if (len_q == LEN_W'(CLOSE_COLOR_LEN) && tag_buf_q[0] == CH_SLASH
				&& tag_buf_q[1] == "c" && tag_buf_q[2] == "o" && tag_buf_q[3] == "l"
				&& tag_buf_q[4] == "o" && tag_buf_q[5] == "r") begin
			tag_kind = CMD_POP_C;
		end else if (len_q == LEN_W'(COLOR_BODY_LEN) && tag_buf_q[0] == "c"
				&& tag_buf_q[1] == "o" && tag_buf_q[2] == "l" && tag_buf_q[3] == "o"
				&& tag_buf_q[4] == "r" && tag_buf_q[5] == CH_EQUALS
				&& tag_buf_q[6] == CH_HASH && hex_ok) begin
			tag_kind = CMD_PUSH_C;
		end else begin
			tag_hit = 1'b0;
		end
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FS_TEXT;
		end else begin
			state_q <= state_d;
		end
	end

	// next state, commands and input stall
	always_comb begin
		state_d    = state_q;
		text_stall = q_full || state_q == FS_FLUSH || state_q == FS_MARK;
		accept     = text_valid && !text_stall;
		cmd_valid  = 1'b0;
		cmd        = '{kind: CMD_LIT, data: text_byte, last: 1'b1,
			done: end_of_text, rgb: tag_rgb};
		buf_we     = 1'b0;
		len_clr    = 1'b0;
		len_inc    = 1'b0;
		fidx_clr   = 1'b0;
		fidx_inc   = 1'b0;
		trail_ld   = 1'b0;
		fidx_m1    = fidx_q - 1'b1;
		case (state_q)
			FS_TEXT: begin
				if (accept) begin
					if (text_byte == CH_OPEN && !end_of_text) begin
						state_d = FS_TAG;
						len_clr = 1'b1;
					end else begin
						cmd_valid = 1'b1;
					end
				end
			end
			FS_TAG: begin
				if (accept) begin
					if (text_byte == CH_CLOSE && tag_hit) begin
						cmd_valid = 1'b1;
						cmd.kind  = tag_kind;
						cmd.last  = !end_of_text;
						cmd.done  = 1'b0;
						len_clr   = 1'b1;
						state_d   = end_of_text ? FS_MARK : FS_TEXT;
					end else if (text_byte != CH_CLOSE && !end_of_text
							&& len_q < LEN_W'(MAX_TAG_LEN)) begin
						buf_we  = 1'b1;
						len_inc = 1'b1;
					end else begin
						trail_ld = 1'b1;
						fidx_clr = 1'b1;
						state_d  = FS_FLUSH;
					end
				end
			end
			FS_FLUSH: begin
				cmd_valid = 1'b1;
				cmd.last  = 1'b0;
				cmd.done  = 1'b0;
				if (fidx_q == '0) begin
					cmd.data = CH_OPEN;
				end else if (fidx_q <= FIDX_W'(len_q)) begin
					cmd.data = tag_buf_q[fidx_m1[TAG_AW-1:0]];
				end else begin
					cmd.data = trail_q;
					cmd.last = 1'b1;
					cmd.done = trail_end_q;
				end
				if (!q_full) begin
					fidx_inc = 1'b1;
					if (cmd.last) begin
						len_clr = 1'b1;
						state_d = FS_TEXT;
					end
				end
			end
			FS_MARK: begin
				cmd_valid = 1'b1;
				cmd.kind  = CMD_MARK;
				cmd.data  = 8'd0;
				cmd.done  = 1'b1;
				if (!q_full) begin
					state_d = FS_TEXT;
				end
			end
			default: begin
				state_d = FS_TEXT;
			end
		endcase
	end

	// tag length and flush index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q  <= '0;
			fidx_q <= '0;
		end else begin
			if (len_clr) begin
				len_q <= '0;
			end else if (len_inc) begin
				len_q <= len_q + 1'b1;
			end
			if (fidx_clr) begin
				fidx_q <= '0;
			end else if (fidx_inc) begin
				fidx_q <= fidx_q + 1'b1;
			end
		end
	end

	// tag body bytes and the byte that ends a rejected tag
	always_ff @(posedge clk) begin
		if (buf_we) begin
			tag_buf_q[len_q[TAG_AW-1:0]] <= text_byte;
		end
		if (trail_ld) begin
			trail_q     <= text_byte;
			trail_end_q <= end_of_text;
		end
	end

endmodule

`default_nettype wire

// ===== sv/bbtp_back.sv =====
`default_nettype none

module bbtp_back
	import bbtp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        base_rgba_we,
	input  wire logic [31:0] base_rgba,
	input  cmd_t             head,
	input  wire logic        head_valid,
	output logic             head_pop,
	output logic             result_valid,
	input  wire logic        result_stall,
	output logic [7:0]       out_byte,
	output logic             has_byte,
	output logic             bold,
	output logic             italic,
	output logic             strike,
	output logic [31:0]      rgba,
	output logic             new_run,
	output logic             stack_overflowed,
	output logic             last_of_step,
	output logic             text_done
);

	logic [31:0]      base_rgba_q;
	logic             bold_q;
	logic             italic_q;
	logic             strike_q;
	logic [31:0]      color_q;
	logic [LVL_W-1:0] levels_q [4];
	logic             bold_stk_q [STACK_DEPTH];
	logic             italic_stk_q [STACK_DEPTH];
	logic             strike_stk_q [STACK_DEPTH];
	logic [31:0]      color_stk_q [STACK_DEPTH];
	logic             break_q;
	logic             ovf_q;
	logic             result_valid_q;

	logic             needs_out;
	logic             is_push;
	logic             is_pop;
	style_t           sty;
	logic [LVL_W-1:0] lv;
	logic [LVL_W-1:0] lv_dec;
	logic             stk_full;
	logic             stk_empty;
	logic [STK_AW-1:0] wr_idx;
	logic [STK_AW-1:0] rd_idx;
	logic             clear;

	// decode the command at the head of the queue
	always_comb begin
		needs_out = 1'b0;
		is_push   = 1'b0;
		is_pop    = 1'b0;
		sty       = STY_BOLD;
		case (head.kind)
			CMD_LIT:    needs_out = 1'b1;
			CMD_MARK:   needs_out = 1'b1;
			CMD_PUSH_B: begin is_push = 1'b1; sty = STY_BOLD;   end
			CMD_PUSH_I: begin is_push = 1'b1; sty = STY_ITALIC; end
			CMD_PUSH_S: begin is_push = 1'b1; sty = STY_STRIKE; end
			CMD_PUSH_C: begin is_push = 1'b1; sty = STY_COLOR;  end
			CMD_POP_B:  begin is_pop = 1'b1;  sty = STY_BOLD;   end
			CMD_POP_I:  begin is_pop = 1'b1;  sty = STY_ITALIC; end
			CMD_POP_S:  begin is_pop = 1'b1;  sty = STY_STRIKE; end
			CMD_POP_C:  begin is_pop = 1'b1;  sty = STY_COLOR;  end
			default:    needs_out = 1'b0;
		endcase
		lv        = levels_q[sty];
		lv_dec    = lv - 1'b1;
		stk_full  = (lv >= LVL_W'(STACK_DEPTH));
		stk_empty = (lv == '0);
		wr_idx    = lv[STK_AW-1:0];
		rd_idx    = lv_dec[STK_AW-1:0];
		head_pop  = head_valid && (!needs_out || !result_valid_q || !result_stall);
		clear     = head_pop && needs_out && head.done;
	end

	// style state and the saved-style stacks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_rgba_q <= BASE_RGBA_RST;
			bold_q      <= 1'b0;
			italic_q    <= 1'b0;
			strike_q    <= 1'b0;
			color_q     <= BASE_RGBA_RST;
			for (int s = 0; s < 4; s++) begin
				levels_q[s] <= LVL_W'(1);
			end
			for (int e = 0; e < STACK_DEPTH; e++) begin
				bold_stk_q[e]   <= 1'b0;
				italic_stk_q[e] <= 1'b0;
				strike_stk_q[e] <= 1'b0;
				color_stk_q[e]  <= BASE_RGBA_RST;
			end
			break_q <= 1'b1;
			ovf_q   <= 1'b0;
		end else begin
			if (clear) begin
				// end of text: back to the reset style
				bold_q   <= 1'b0;
				italic_q <= 1'b0;
				strike_q <= 1'b0;
				color_q  <= base_rgba_q;
				for (int s = 0; s < 4; s++) begin
					levels_q[s] <= LVL_W'(1);
				end
				bold_stk_q[0]   <= 1'b0;
				italic_stk_q[0] <= 1'b0;
				strike_stk_q[0] <= 1'b0;
				color_stk_q[0]  <= base_rgba_q;
				break_q <= 1'b1;
				ovf_q   <= 1'b0;
			end else if (head_pop) begin
				if (head.kind == CMD_LIT) begin
					break_q <= 1'b0;
				end
				if (is_push) begin
					break_q <= 1'b1;
					if (stk_full) begin
						ovf_q <= 1'b1;
					end else begin
						levels_q[sty] <= lv + 1'b1;
						case (sty)
							STY_BOLD: begin
								bold_stk_q[wr_idx] <= bold_q;
								bold_q <= 1'b1;
							end
							STY_ITALIC: begin
								italic_stk_q[wr_idx] <= italic_q;
								italic_q <= 1'b1;
							end
							STY_STRIKE: begin
								strike_stk_q[wr_idx] <= strike_q;
								strike_q <= 1'b1;
							end
							default: begin
								color_stk_q[wr_idx] <= color_q;
								color_q <= {head.rgb, ALPHA_OPAQUE};
							end
						endcase
					end
				end
				if (is_pop) begin
					break_q <= 1'b1;
					if (!stk_empty) begin
						levels_q[sty] <= lv_dec;
						case (sty)
							STY_BOLD:   bold_q   <= bold_stk_q[rd_idx];
							STY_ITALIC: italic_q <= italic_stk_q[rd_idx];
							STY_STRIKE: strike_q <= strike_stk_q[rd_idx];
							default:    color_q  <= color_stk_q[rd_idx];
						endcase
					end
				end
			end
			// register write; the user must write only while idle, the block does not enforce it
			if (base_rgba_we) begin
				base_rgba_q    <= base_rgba;
				color_stk_q[0] <= base_rgba;
				if (levels_q[STY_COLOR] <= LVL_W'(1)) begin
					color_q <= base_rgba;
				end
			end
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (head_pop && needs_out) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (head_pop && needs_out) begin
			out_byte         <= (head.kind == CMD_LIT) ? head.data : 8'd0;
			has_byte         <= (head.kind == CMD_LIT);
			bold             <= bold_q;
			italic           <= italic_q;
			strike           <= strike_q;
			rgba             <= color_q;
			new_run          <= (head.kind == CMD_LIT) && break_q;
			stack_overflowed <= ovf_q;
			last_of_step     <= head.last;
			text_done        <= head.done;
		end
	end

	assign result_valid = result_valid_q;

endmodule

`default_nettype wire

// ===== sv/bbcode_style_tag_parser.sv =====
// channel   | handshake                  | payload
// ----------+----------------------------+--------------------------------------------
// text in   | text_valid / text_stall    | text_byte, end_of_text
// result    | result_valid / result_stall| out_byte, has_byte, bold, italic, strike,
//           |                            | rgba, new_run, stack_overflowed,
//           |                            | last_of_step, text_done
// config    | base_rgba_we               | base_rgba
//
// plain text and tag body bytes are accepted one per cycle while text_stall is low; a
// literal passes through a command queue entry and then the output register.
// a rejected or overlong tag with n body bytes flushes as n+2 literals, one per cycle while
// the queue has room, and the front stalls text input; a tag closed on the final byte adds an end marker.
// the four-entry command queue lets the front keep scanning while result_stall holds the back.
// arst_n clears all control state; the style stacks come up at their base entries.
`default_nettype none

module bbcode_style_tag_parser
	import bbtp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        base_rgba_we,
	input  wire logic [31:0] base_rgba,
	input  wire logic        text_valid,
	output logic             text_stall,
	input  wire logic [7:0]  text_byte,
	input  wire logic        end_of_text,
	output logic             result_valid,
	input  wire logic        result_stall,
	output logic [7:0]       out_byte,
	output logic             has_byte,
	output logic             bold,
	output logic             italic,
	output logic             strike,
	output logic [31:0]      rgba,
	output logic             new_run,
	output logic             stack_overflowed,
	output logic             last_of_step,
	output logic             text_done
);

	cmd_t front_cmd;
	logic front_cmd_valid;
	logic q_full;
	cmd_t q_head;
	logic q_not_empty;
	logic q_pop;

	// scanner and tag classifier
	bbtp_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.text_valid  (text_valid),
		.text_stall  (text_stall),
		.text_byte   (text_byte),
		.end_of_text (end_of_text),
		.cmd_valid   (front_cmd_valid),
		.cmd         (front_cmd),
		.q_full      (q_full)
	);

	// command queue
	bbtp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (front_cmd_valid),
		.push_data (front_cmd),
		.full      (q_full),
		.pop       (q_pop),
		.head      (q_head),
		.not_empty (q_not_empty)
	);

	// style engine and output register
	bbtp_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.base_rgba_we     (base_rgba_we),
		.base_rgba        (base_rgba),
		.head             (q_head),
		.head_valid       (q_not_empty),
		.head_pop         (q_pop),
		.result_valid     (result_valid),
		.result_stall     (result_stall),
		.out_byte         (out_byte),
		.has_byte         (has_byte),
		.bold             (bold),
		.italic           (italic),
		.strike           (strike),
		.rgba             (rgba),
		.new_run          (new_run),
		.stack_overflowed (stack_overflowed),
		.last_of_step     (last_of_step),
		.text_done        (text_done)
	);

endmodule

`default_nettype wire

// ===== sv/bbtp_checker.sv =====
`default_nettype none

module bbtp_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        result_valid,
	input wire logic        result_stall,
	input wire logic [7:0]  out_byte,
	input wire logic        has_byte,
	input wire logic        bold,
	input wire logic        italic,
	input wire logic        strike,
	input wire logic [31:0] rgba,
	input wire logic        new_run,
	input wire logic        stack_overflowed,
	input wire logic        last_of_step,
	input wire logic        text_done
);

	// a stalled result stays offered
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result dropped while stalled");

	// end of text closes the step too
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && text_done |-> last_of_step)
		else $error("text_done without last_of_step");

	// a bare end marker only ends the text and carries no byte
	a_bare: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !has_byte |-> text_done && out_byte == 8'd0 && !new_run)
		else $error("malformed end marker");

	// a run starts only on a real byte
	a_run: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && new_run |-> has_byte)
		else $error("new_run on empty result");

	// a stalled result keeps its payload
	a_stable: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> $stable({out_byte, has_byte, bold, italic, strike,
			rgba, new_run, stack_overflowed, last_of_step, text_done}))
		else $error("result payload changed while stalled");

endmodule

bind bbcode_style_tag_parser bbtp_checker u_bbtp_checker (.*);

`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
	import bbtp_pkg::*;

	localparam int QUIET_LIMIT      = 2000;
	localparam int DRAIN_CYCLES     = 24;
	localparam int HOLD_CYCLES      = 300;
	localparam int BYTES_PER_PHASE  = 110;
	localparam int N_DIRECTED       = 29;

	// one styled character as it leaves the parser
	typedef struct packed {
		logic [7:0]  chr;
		logic        has;
		logic        bold;
		logic        italic;
		logic        strike;
		logic [31:0] rgba;
		logic        new_run;
		logic        ovf;
		logic        last;
		logic        done;
	} styled_char_t;

	// directed row: a text byte, or a base colour write
	typedef struct packed {
		logic        cfg;
		logic [7:0]  chr;
		logic        eot;
		logic        typed;
		logic [7:0]  want_chr;
		logic        want_has;
		logic [31:0] word;     // colour to write, or rgba of the last result
	} dir_row_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        base_rgba_we = 1'b0;
	logic [31:0] base_rgba = 32'h0;
	logic        text_valid = 1'b0;
	logic        text_stall;
	logic [7:0]  text_byte = 8'h00;
	logic        end_of_text = 1'b0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	logic [7:0]  out_byte;
	logic        has_byte;
	logic        bold;
	logic        italic;
	logic        strike;
	logic [31:0] rgba;
	logic        new_run;
	logic        stack_overflowed;
	logic        last_of_step;
	logic        text_done;

	wire in_fire  = text_valid & ~text_stall;
	wire out_fire = result_valid & ~result_stall;

	bbcode_style_tag_parser u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.base_rgba_we     (base_rgba_we),
		.base_rgba        (base_rgba),
		.text_valid       (text_valid),
		.text_stall       (text_stall),
		.text_byte        (text_byte),
		.end_of_text      (end_of_text),
		.result_valid     (result_valid),
		.result_stall     (result_stall),
		.out_byte         (out_byte),
		.has_byte         (has_byte),
		.bold             (bold),
		.italic           (italic),
		.strike           (strike),
		.rgba             (rgba),
		.new_run          (new_run),
		.stack_overflowed (stack_overflowed),
		.last_of_step     (last_of_step),
		.text_done        (text_done)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// predicted parser state
	front_state_t scan_state;
	logic [7:0]   tag_body [MAX_TAG_LEN];
	int           body_len;
	logic         cur_bold, cur_italic, cur_strike;
	logic [31:0]  cur_color, base_color;
	logic         saved_bold [STACK_DEPTH];
	logic         saved_italic [STACK_DEPTH];
	logic         saved_strike [STACK_DEPTH];
	logic [31:0]  saved_color [STACK_DEPTH];
	int           stack_level [4];
	logic         run_break, ovf_sticky;

	styled_char_t styled_q [$];
	styled_char_t step_out [$];
	logic [7:0]   markup_q [$];

	int errors = 0;
	int results_checked = 0;
	int bytes_in = 0;
	int texts_in = 0;
	int ovf_results = 0;
	int colour_writes = 0;
	int items_sent = 0;
	int send_idle_pct = 29;
	int recv_idle_pct = 78;
	bit hold_req = 1'b0;

	// expectation typed into the directed table for the byte on offer
	logic        typed_on = 1'b0;
	logic [7:0]  typed_chr;
	logic        typed_has;
	logic [31:0] typed_rgba;

	dir_row_t directed_rows [N_DIRECTED] = '{
		'{1'b0, 8'h00,    1'b0, 1'b1, 8'h00,    1'b1, 32'hFFFF_FFFF},
		'{1'b0, CH_OPEN,  1'b0, 1'b0, 8'h00,    1'b0, 32'h0},
		'{1'b0, "b",      1'b0, 1'b0, 8'h00,    1'b0, 32'h0},
		'{1'b0, CH_CLOSE, 1'b0, 1'b0, 8'h00,    1'b0, 32'h0},
		'{1'b0, 8'hFF,    1'b0, 1'b1, 8'hFF,    1'b1, 32'hFFFF_FFFF},
		'{1'b0, CH_OPEN,  1'b0, 1'b0, 8'h00,    1'b0, 32'h0},
		'{1'b0, "c",      1'b0, 1'b0, 8'h00,    1'b0, 32'h0},
		'{1'b0, "o",      1'b0, 1'b0, 8'h00,    1'b0, 32'h0},
		'{1'b0, "l",      1'b0, 1'b0, 8'h00,    1'b0, 32'h0},
		'{1'b0, "o",      1'b0, 1'b0, 8'h00,    1'b0, 32'h0},
		'{1'b0, "r",      1'b0, 1'b0, 8'h00,    1'b0, 32'h0},
		'{1'b0, "=",      1'b0, 1'b0, 8'h00,    1'b0, 32'h0},
		'{1'b0, "#",      1'b0, 1'b0, 8'h00,    1'b0, 32'h0},
		'{1'b0, "a",      1'b0, 1'b0, 8'h00,    1'b0, 32'h0},
		'{1'b0, "0",      1'b0, 1'b0, 8'h00,    1'b0, 32'h0},
		'{1'b0, "B",      1'b0, 1'b0, 8'h00,    1'b0, 32'h0},
		'{1'b0, "1",      1'b0, 1'b0, 8'h00,    1'b0, 32'h0},
		'{1'b0, "c",      1'b0, 1'b0, 8'h00,    1'b0, 32'h0},
		'{1'b0, "2",      1'b0, 1'b0, 8'h00,    1'b0, 32'h0},
		'{1'b0, CH_CLOSE, 1'b0, 1'b0, 8'h00,    1'b0, 32'h0},
		// stray close bracket, coloured by the tag above
		'{1'b0, CH_CLOSE, 1'b0, 1'b1, CH_CLOSE, 1'b1, 32'hA0B1_C2FF},
		// base colour change while a colour tag is open
		'{1'b1, 8'h00,    1'b0, 1'b0, 8'h00,    1'b0, 32'h0000_0000},
		// trailing bracket keeps the tag colour
		'{1'b0, CH_OPEN,  1'b1, 1'b1, CH_OPEN,  1'b1, 32'hA0B1_C2FF},
		// unterminated tag at the end picks up the new base colour
		'{1'b0, CH_OPEN,  1'b0, 1'b0, 8'h00,    1'b0, 32'h0},
		'{1'b0, "x",      1'b1, 1'b1, "x",      1'b1, 32'h0000_0000},
		// tag closed on the final byte gives a bare end marker
		'{1'b0, CH_OPEN,  1'b0, 1'b0, 8'h00,    1'b0, 32'h0},
		'{1'b0, "/",      1'b0, 1'b0, 8'h00,    1'b0, 32'h0},
		'{1'b0, "s",      1'b0, 1'b0, 8'h00,    1'b0, 32'h0},
		'{1'b0, CH_CLOSE, 1'b1, 1'b1, 8'h00,    1'b0, 32'h0000_0000}
	};

	task automatic report_err(input string what, input logic [31:0] got, input logic [31:0] want);
		errors++;
		$display("mismatch at result %0d: %s got %0h expected %0h",
			results_checked, what, got, want);
	endtask

	// back to the start of a text
	function automatic void clear_markup_state();
		int k;
		scan_state = FS_TEXT;
		body_len = 0;
		cur_bold = 1'b0;
		cur_italic = 1'b0;
		cur_strike = 1'b0;
		cur_color = base_color;
		for (k = 0; k < STACK_DEPTH; k++) begin
			saved_bold[k] = 1'b0;
			saved_italic[k] = 1'b0;
			saved_strike[k] = 1'b0;
			saved_color[k] = 32'h0;
		end
		saved_color[0] = base_color;
		for (k = 0; k < 4; k++)
			stack_level[k] = 1;
		run_break = 1'b1;
		ovf_sticky = 1'b0;
	endfunction

	function automatic bit push_saved(input style_t w);
		int lv;
		lv = stack_level[w];
		if (lv >= STACK_DEPTH) begin
			ovf_sticky = 1'b1;
			return 1'b0;
		end
		case (w)
			STY_BOLD:   saved_bold[lv] = cur_bold;
			STY_ITALIC: saved_italic[lv] = cur_italic;
			STY_STRIKE: saved_strike[lv] = cur_strike;
			default:    saved_color[lv] = cur_color;
		endcase
		stack_level[w] = lv + 1;
		return 1'b1;
	endfunction

	function automatic void pop_saved(input style_t w);
		int lv;
		lv = stack_level[w];
		if (lv == 0 || lv > STACK_DEPTH)
			return;
		lv--;
		stack_level[w] = lv;
		case (w)
			STY_BOLD:   cur_bold = saved_bold[lv];
			STY_ITALIC: cur_italic = saved_italic[lv];
			STY_STRIKE: cur_strike = saved_strike[lv];
			default:    cur_color = saved_color[lv];
		endcase
	endfunction

	function automatic bit body_is(input string s);
		int k;
		if (body_len != s.len())
			return 1'b0;
		for (k = 0; k < body_len; k++)
			if (tag_body[k] != s[k])
				return 1'b0;
		return 1'b1;
	endfunction

	// strict hex: anything outside 0-9, a-f, A-F gives 16
	function automatic int hex_nibble(input logic [7:0] c);
		if (c >= "0" && c <= "9")
			return c - "0";
		if (c >= "a" && c <= "f")
			return c - "a" + 10;
		if (c >= "A" && c <= "F")
			return c - "A" + 10;
		return 16;
	endfunction

	// act on a closed tag body; 0 means it is literal text
	function automatic bit take_tag();
		string prefix;
		logic [23:0] rgb;
		bit hit, is_color;
		int k, d;
		prefix = "color=#";
		hit = 1'b1;
		is_color = (body_len == COLOR_BODY_LEN);
		if (is_color)
			for (k = 0; k < 7; k++)
				if (tag_body[k] != prefix[k])
					is_color = 1'b0;
		if (body_is("b")) begin
			if (push_saved(STY_BOLD))
				cur_bold = 1'b1;
		end else if (body_is("/b")) begin
			pop_saved(STY_BOLD);
		end else if (body_is("i")) begin
			if (push_saved(STY_ITALIC))
				cur_italic = 1'b1;
		end else if (body_is("/i")) begin
			pop_saved(STY_ITALIC);
		end else if (body_is("s")) begin
			if (push_saved(STY_STRIKE))
				cur_strike = 1'b1;
		end else if (body_is("/s")) begin
			pop_saved(STY_STRIKE);
		end else if (body_is("/color")) begin
			pop_saved(STY_COLOR);
		end else if (is_color) begin
			rgb = 24'h0;
			for (k = 7; k < COLOR_BODY_LEN; k++) begin
				d = hex_nibble(tag_body[k]);
				if (d > 15)
					return 1'b0;
				rgb = {rgb[19:0], d[3:0]};
			end
			if (push_saved(STY_COLOR))
				cur_color = {rgb, ALPHA_OPAQUE};
		end else begin
			hit = 1'b0;
		end
		if (hit)
			run_break = 1'b1;
		return hit;
	endfunction

	function automatic void emit(input logic [7:0] c, input logic has);
		styled_char_t r;
		r.chr = has ? c : 8'h00;
		r.has = has;
		r.bold = cur_bold;
		r.italic = cur_italic;
		r.strike = cur_strike;
		r.rgba = cur_color;
		r.new_run = has & run_break;
		r.ovf = ovf_sticky;
		r.last = 1'b0;
		r.done = 1'b0;
		if (has)
			run_break = 1'b0;
		step_out = {step_out, r};
	endfunction

	function automatic void flush_body();
		int k;
		emit(CH_OPEN, 1'b1);
		for (k = 0; k < body_len; k++)
			emit(tag_body[k], 1'b1);
		scan_state = FS_TEXT;
		body_len = 0;
	endfunction

	// styled characters caused by one text byte, appended to styled_q
	function automatic int parse_markup(input logic [7:0] c, input logic eot);
		int n;
		step_out.delete();
		if (scan_state == FS_TAG) begin
			if (c == CH_CLOSE) begin
				if (!take_tag()) begin
					flush_body();
					emit(CH_CLOSE, 1'b1);
				end
				scan_state = FS_TEXT;
				body_len = 0;
			end else if (body_len < MAX_TAG_LEN) begin
				tag_body[body_len] = c;
				body_len++;
				if (eot)
					flush_body();
			end else begin
				flush_body();
				emit(c, 1'b1);
			end
		end else if (c == CH_OPEN && !eot) begin
			scan_state = FS_TAG;
			body_len = 0;
		end else begin
			emit(c, 1'b1);
		end
		if (eot) begin
			if (step_out.size() == 0)
				emit(8'h00, 1'b0);
			step_out[step_out.size() - 1].done = 1'b1;
			clear_markup_state();
		end
		n = step_out.size();
		if (n > 0)
			step_out[n - 1].last = 1'b1;
		styled_q = {styled_q, step_out};
		return n;
	endfunction

	function automatic void set_base_color(input logic [31:0] v);
		base_color = v;
		saved_color[0] = v;
		if (stack_level[STY_COLOR] <= 1)
			cur_color = v;
	endfunction

	task automatic check_result();
		styled_char_t got, want;
		got = '{out_byte, has_byte, bold, italic, strike, rgba, new_run,
			stack_overflowed, last_of_step, text_done};
		if (styled_q.size() == 0) begin
			report_err("result with nothing expected, out_byte", got.chr, 32'h0);
			return;
		end
		want = styled_q.pop_front();
		if (want.ovf)
			ovf_results++;
		if (got.chr !== want.chr) report_err("out_byte", got.chr, want.chr);
		if (got.has !== want.has) report_err("has_byte", got.has, want.has);
		if (got.bold !== want.bold) report_err("bold", got.bold, want.bold);
		if (got.italic !== want.italic) report_err("italic", got.italic, want.italic);
		if (got.strike !== want.strike) report_err("strike", got.strike, want.strike);
		if (got.rgba !== want.rgba) report_err("rgba", got.rgba, want.rgba);
		if (got.new_run !== want.new_run) report_err("new_run", got.new_run, want.new_run);
		if (got.ovf !== want.ovf) report_err("stack_overflowed", got.ovf, want.ovf);
		if (got.last !== want.last) report_err("last_of_step", got.last, want.last);
		if (got.done !== want.done) report_err("text_done", got.done, want.done);
		results_checked++;
	endtask

	// predictor and checker, all on the rising edge
	always @(posedge clk) begin : monitor
		int n;
		if (!arst_n) begin
			base_color = BASE_RGBA_RST;
			clear_markup_state();
			styled_q.delete();
		end else begin
			if (base_rgba_we)
				set_base_color(base_rgba);
			if (in_fire) begin
				n = parse_markup(text_byte, end_of_text);
				bytes_in++;
				if (end_of_text)
					texts_in++;
				if (typed_on) begin
					if (n == 0)
						report_err("directed byte gave no result", 32'h0, 32'h1);
					else begin
						if (styled_q[$].chr !== typed_chr)
							report_err("directed out_byte", styled_q[$].chr, typed_chr);
						if (styled_q[$].has !== typed_has)
							report_err("directed has_byte", styled_q[$].has, typed_has);
						if (styled_q[$].rgba !== typed_rgba)
							report_err("directed rgba", styled_q[$].rgba, typed_rgba);
					end
				end
			end
			if (out_fire)
				check_result();
		end
	end

	// result side: random stall, or one long hold-off on request
	initial begin : receiver
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				result_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else begin
				result_stall <= ($urandom_range(99) < recv_idle_pct);
			end
		end
	end

	// ends the run when nothing moves for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if (!arst_n || in_fire || out_fire || base_rgba_we)
				quiet = 0;
			else
				quiet++;
		end
		$display("timeout after %0d quiet cycles", QUIET_LIMIT);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// offer one byte from a falling edge, return at the falling edge after acceptance
	task automatic send_byte(input logic [7:0] c, input logic eot);
		while ($urandom_range(99) < send_idle_pct) begin
			text_valid <= 1'b0;
			@(negedge clk);
		end
		text_valid <= 1'b1;
		text_byte <= c;
		end_of_text <= eot;
		@(posedge clk);
		while (text_stall)
			@(posedge clk);
		@(negedge clk);
		items_sent++;
	endtask

	task automatic wait_drained();
		while (styled_q.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_color(input logic [31:0] v);
		base_rgba_we <= 1'b1;
		base_rgba <= v;
		@(negedge clk);
		base_rgba_we <= 1'b0;
		colour_writes++;
	endtask

	task automatic add_byte(input logic [7:0] c);
		markup_q = {markup_q, c};
	endtask

	task automatic add_str(input string s);
		int k;
		for (k = 0; k < s.len(); k++)
			add_byte(s[k]);
	endtask

	function automatic logic [7:0] hex_char();
		string digits;
		digits = "0123456789abcdefABCDEF";
		return digits[$urandom_range(21)];
	endfunction

	// colour tag with a given digit count, one digit spoilt where bad_at is in range
	task automatic add_colour_tag(input int digits, input int bad_at);
		string junk;
		int k;
		junk = "gGzZ.:/@ #-xX";
		add_str("[color=#");
		for (k = 0; k < digits; k++)
			add_byte((k == bad_at) ? junk[$urandom_range(12)] : hex_char());
		add_byte(CH_CLOSE);
	endtask

	task automatic add_open(input style_t w);
		case (w)
			STY_BOLD:   add_str("[b]");
			STY_ITALIC: add_str("[i]");
			STY_STRIKE: add_str("[s]");
			default:    add_colour_tag(6, -1);
		endcase
	endtask

	task automatic add_close(input style_t w);
		case (w)
			STY_BOLD:   add_str("[/b]");
			STY_ITALIC: add_str("[/i]");
			STY_STRIKE: add_str("[/s]");
			default:    add_str("[/color]");
		endcase
	endtask

	// one text: mostly well formed markup, some noise and broken tags
	task automatic build_text();
		int goal, pick, cnt, k;
		style_t w;
		logic [7:0] c;
		markup_q.delete();
		goal = $urandom_range(40, 3);
		while (markup_q.size() < goal) begin
			pick = $urandom_range(99);
			w = style_t'($urandom_range(3));
			if (pick < 30) begin
				cnt = $urandom_range(4, 1);
				repeat (cnt)
					add_byte(8'(($urandom_range(7) == 0) ?
						$urandom_range(255) : $urandom_range(126, 32)));
			end else if (pick < 55) begin
				add_open(w);
			end else if (pick < 72) begin
				add_close(w);
			end else if (pick < 77) begin
				// nested opens, enough to fill the stack and sometimes overflow it
				if (w == STY_COLOR && $urandom_range(3) != 0)
					w = STY_BOLD;
				cnt = (w == STY_COLOR) ? $urandom_range(8, 7) : $urandom_range(9, 6);
				repeat (cnt)
					add_open(w);
			end else if (pick < 82) begin
				case ($urandom_range(2))
					0: add_colour_tag(6, $urandom_range(5));
					1: add_colour_tag($urandom_range(1) ? 7 : 5, -1);
					default: add_str("[COLOR=#00ff00]");
				endcase
			end else if (pick < 90) begin
				// random body, sometimes too long for the buffer
				add_byte(CH_OPEN);
				cnt = $urandom_range(MAX_TAG_LEN + 3);
				for (k = 0; k < cnt; k++) begin
					c = 8'($urandom_range(255));
					add_byte((c == CH_CLOSE) ? "x" : c);
				end
				add_byte(CH_CLOSE);
			end else if (pick < 95) begin
				add_str($urandom_range(1) ? "[[b]" : "[/[i]");
			end else begin
				add_byte(CH_CLOSE);
			end
		end
		// sometimes stop inside a tag
		case ($urandom_range(9))
			0: add_byte(CH_OPEN);
			1: add_str("[ab");
			2: add_close(style_t'($urandom_range(3)));
			default: ;
		endcase
	endtask

	initial begin : stimulus
		int r, p, k, goal;
		logic [31:0] colour_val;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed table
		for (r = 0; r < N_DIRECTED; r++) begin
			if (directed_rows[r].cfg) begin
				text_valid <= 1'b0;
				wait_drained();
				write_color(directed_rows[r].word);
			end else begin
				typed_on = directed_rows[r].typed;
				typed_chr = directed_rows[r].want_chr;
				typed_has = directed_rows[r].want_has;
				typed_rgba = directed_rows[r].word;
				send_byte(directed_rows[r].chr, directed_rows[r].eot);
			end
		end
		typed_on = 1'b0;
		text_valid <= 1'b0;
		wait_drained();

		// random texts under three idling patterns
		for (p = 0; p < 3; p++) begin
			case (p)
				0: begin
					send_idle_pct = 29;
					recv_idle_pct = 78;
					colour_val = $urandom;
				end
				1: begin
					send_idle_pct = 78;
					recv_idle_pct = 29;
					colour_val = 32'hFFFF_FFFF;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
					colour_val = $urandom;
				end
			endcase
			write_color(colour_val);
			// last phase: back end held off while text keeps coming
			if (p == 2)
				hold_req = 1'b1;
			goal = items_sent + BYTES_PER_PHASE;
			while (items_sent < goal) begin
				build_text();
				for (k = 0; k < markup_q.size(); k++)
					send_byte(markup_q[k], k == markup_q.size() - 1);
			end
			text_valid <= 1'b0;
			wait_drained();
		end

		if (styled_q.size() != 0)
			report_err("results never delivered", styled_q.size(), 32'h0);
		$display("covered %0d text bytes in %0d texts, %0d styled results checked",
			bytes_in, texts_in, results_checked);
		$display("%0d results under the overflow flag, base colour written %0d times",
			ovf_results, colour_writes);
		if (errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
